[rtl/core/xysmp_pkg.sv]
`default_nettype none
package xysmp_pkg;

	localparam int DIV_W = 52;
	localparam int DVS_W = 32;
	localparam int CNT_W = 6;

	localparam int CLOCK_HZ_DEF = 16000000;
	localparam logic [23:0] COMPARE_MAX = 24'hFFFFFF;

	localparam logic [15:0] PPR_RST = 16'd1000;
	localparam logic [7:0] PITCH_RST = 8'd8;
	localparam logic [19:0] BASE_RST = 20'd10000;
	localparam logic [19:0] MIN_RST = 20'd100;

	typedef enum logic [1:0] {
		CFG_PPR = 2'd0,
		CFG_PITCH = 2'd1,
		CFG_BASE = 2'd2,
		CFG_MIN = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_WAIT,
		ST_NEXT,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		OP_PX,
		OP_PY,
		OP_RATIO,
		OP_CMPX,
		OP_CMPY
	} op_t;

	typedef struct packed {
		logic start;
		logic [CNT_W-1:0] iters;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage
`default_nettype wire

[rtl/core/xysmp_div.sv]
`default_nettype none
// restoring divider, one quotient bit per cycle, dividend MSB-aligned
module xysmp_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire xysmp_pkg::div_ctl_t ctl,
	input wire logic [xysmp_pkg::DIV_W-1:0] dividend,
	input wire logic [xysmp_pkg::DVS_W-1:0] divisor,
	output xysmp_pkg::div_sts_t sts,
	output logic [xysmp_pkg::DIV_W-1:0] quotient
);

	logic [xysmp_pkg::CNT_W-1:0] cnt_q;
	logic done_q;
	logic [xysmp_pkg::DIV_W-1:0] dvd_q;
	logic [xysmp_pkg::DIV_W-1:0] quo_q;
	logic [xysmp_pkg::DVS_W-1:0] rem_q;
	logic [xysmp_pkg::DVS_W-1:0] dvs_q;
	logic [xysmp_pkg::DVS_W:0] shifted;
	logic [xysmp_pkg::DVS_W:0] diff;
	logic fits;

	assign shifted = {rem_q, dvd_q[xysmp_pkg::DIV_W-1]};
	assign fits = shifted >= {1'b0, dvs_q};
	assign diff = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				cnt_q <= ctl.iters;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == xysmp_pkg::CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[xysmp_pkg::DIV_W-2:0], 1'b0};
			rem_q <= fits ? diff[xysmp_pkg::DVS_W-1:0] : shifted[xysmp_pkg::DVS_W-1:0];
			quo_q <= {quo_q[xysmp_pkg::DIV_W-2:0], fits};
		end
	end

	assign sts.busy = cnt_q != '0;
	assign sts.done = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

[rtl/core/xy_stepper_move_planner.sv]
`default_nettype none
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall  | target_x, target_y
// out     | output    | out_valid / out_stall| dir, pulses, enable, compare per axis
// cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// A move runs two step-count divisions, a ratio division when an axis is slowed,
// and one division for each enabled compare value, all through the shared
// bit-serial divider. in_stall is high from acceptance until the result beat is
// taken. Reset restores the register defaults and zeroes both positions.
module xy_stepper_move_planner #(
	parameter int CLOCK_HZ = xysmp_pkg::CLOCK_HZ_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [15:0] target_x,
	input wire logic [15:0] target_y,
	output logic out_valid,
	input wire logic out_stall,
	output logic dir_x,
	output logic dir_y,
	output logic [31:0] pulses_x,
	output logic [31:0] pulses_y,
	output logic enable_x,
	output logic enable_y,
	output logic [23:0] compare_x,
	output logic [23:0] compare_y,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [19:0] cfg_data
);

	localparam int CLK_W = $clog2(CLOCK_HZ + 1);
	localparam int DW = xysmp_pkg::DIV_W;

	xysmp_pkg::state_t state_q, state_d;
	xysmp_pkg::op_t op_q, op_d;

	logic [15:0] ppr_q;
	logic [7:0] pitch_q;
	logic [19:0] base_q;
	logic [19:0] min_q;
	logic [15:0] pos_x_q, pos_y_q;
	logic [15:0] dist_x_q, dist_y_q;
	logic dir_x_q, dir_y_q;
	logic [31:0] px_q, py_q;
	logic [19:0] fx_q, fy_q;
	logic [23:0] cmp_x_q, cmp_y_q;
	logic slow_y_q;

	logic accept;
	logic en_x, en_y;
	logic need_x, need_y;
	logic [7:0] pitch_eff;
	logic [31:0] mul_a;
	logic [19:0] mul_b;
	logic [51:0] product;
	logic [DW-1:0] quotient;
	logic [DW-1:0] quo_m1;
	logic [23:0] cmp_val;
	logic [DW-1:0] dividend;
	logic [31:0] divisor;
	logic div_start;
	logic [xysmp_pkg::CNT_W-1:0] div_iters;
	xysmp_pkg::div_ctl_t div_ctl;
	xysmp_pkg::div_sts_t div_sts;

	assign accept = in_valid && !in_stall;
	assign in_stall = state_q != xysmp_pkg::ST_IDLE;
	assign out_valid = state_q == xysmp_pkg::ST_OUT;

	assign en_x = fx_q > min_q;
	assign en_y = fy_q > min_q;
	assign need_y = (px_q > py_q) && (py_q != '0);
	assign need_x = (py_q > px_q) && (px_q != '0);
	assign pitch_eff = (pitch_q == '0) ? 8'd1 : pitch_q;

	// shared multiplier feeding the divider's dividend register
	always_comb begin
		mul_a = {16'd0, dist_x_q};
		mul_b = {4'd0, ppr_q};
		dividend = '0;
		divisor = 32'd1;
		div_iters = xysmp_pkg::CNT_W'(32);
		case (op_q)
			xysmp_pkg::OP_PX: begin
				dividend = {product[31:0], 20'd0};
				divisor = {24'd0, pitch_eff};
			end
			xysmp_pkg::OP_PY: begin
				mul_a = {16'd0, dist_y_q};
				dividend = {product[31:0], 20'd0};
				divisor = {24'd0, pitch_eff};
			end
			xysmp_pkg::OP_RATIO: begin
				mul_a = slow_y_q ? py_q : px_q;
				mul_b = base_q;
				dividend = product;
				divisor = slow_y_q ? px_q : py_q;
				div_iters = xysmp_pkg::CNT_W'(DW);
			end
			xysmp_pkg::OP_CMPX: begin
				dividend = DW'(CLOCK_HZ) << (DW - CLK_W);
				divisor = {11'd0, fx_q, 1'b0};
				div_iters = xysmp_pkg::CNT_W'(CLK_W);
			end
			xysmp_pkg::OP_CMPY: begin
				dividend = DW'(CLOCK_HZ) << (DW - CLK_W);
				divisor = {11'd0, fy_q, 1'b0};
				div_iters = xysmp_pkg::CNT_W'(CLK_W);
			end
			default: begin
				dividend = '0;
			end
		endcase
	end

	assign product = mul_a * mul_b;
	assign div_ctl = {div_start, div_iters};

	xysmp_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(div_ctl),
		.dividend(dividend),
		.divisor(divisor),
		.sts(div_sts),
		.quotient(quotient)
	);

	assign quo_m1 = quotient - 1'b1;
	assign cmp_val = (quotient == '0) ? 24'd0 :
		(quo_m1 > DW'(xysmp_pkg::COMPARE_MAX)) ? xysmp_pkg::COMPARE_MAX : quo_m1[23:0];

	always_comb begin
		state_d = state_q;
		op_d = op_q;
		div_start = 1'b0;
		case (state_q)
			xysmp_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = xysmp_pkg::ST_LOAD;
					op_d = xysmp_pkg::OP_PX;
				end
			end
			xysmp_pkg::ST_LOAD: begin
				div_start = 1'b1;
				state_d = xysmp_pkg::ST_WAIT;
			end
			xysmp_pkg::ST_WAIT: begin
				if (div_sts.done) begin
					state_d = xysmp_pkg::ST_NEXT;
				end
			end
			xysmp_pkg::ST_NEXT: begin
				state_d = xysmp_pkg::ST_LOAD;
				case (op_q)
					xysmp_pkg::OP_PX: op_d = xysmp_pkg::OP_PY;
					xysmp_pkg::OP_PY, xysmp_pkg::OP_RATIO: begin
						if (op_q == xysmp_pkg::OP_PY && (need_x || need_y)) begin
							op_d = xysmp_pkg::OP_RATIO;
						end else if (en_x) begin
							op_d = xysmp_pkg::OP_CMPX;
						end else if (en_y) begin
							op_d = xysmp_pkg::OP_CMPY;
						end else begin
							state_d = xysmp_pkg::ST_OUT;
						end
					end
					xysmp_pkg::OP_CMPX: begin
						if (en_y) begin
							op_d = xysmp_pkg::OP_CMPY;
						end else begin
							state_d = xysmp_pkg::ST_OUT;
						end
					end
					default: state_d = xysmp_pkg::ST_OUT;
				endcase
			end
			xysmp_pkg::ST_OUT: begin
				if (!out_stall) begin
					state_d = xysmp_pkg::ST_IDLE;
				end
			end
			default: state_d = xysmp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xysmp_pkg::ST_IDLE;
			op_q <= xysmp_pkg::OP_PX;
			ppr_q <= xysmp_pkg::PPR_RST;
			pitch_q <= xysmp_pkg::PITCH_RST;
			base_q <= xysmp_pkg::BASE_RST;
			min_q <= xysmp_pkg::MIN_RST;
			pos_x_q <= '0;
			pos_y_q <= '0;
		end else begin
			state_q <= state_d;
			op_q <= op_d;
			if (cfg_we) begin
				case (xysmp_pkg::cfg_idx_t'(cfg_index))
					xysmp_pkg::CFG_PPR: ppr_q <= cfg_data[15:0];
					xysmp_pkg::CFG_PITCH: pitch_q <= cfg_data[7:0];
					xysmp_pkg::CFG_BASE: base_q <= cfg_data;
					xysmp_pkg::CFG_MIN: min_q <= cfg_data;
					default: ppr_q <= ppr_q;
				endcase
			end
			if (accept) begin
				pos_x_q <= target_x;
				pos_y_q <= target_y;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dir_x_q <= target_x >= pos_x_q;
			dir_y_q <= target_y >= pos_y_q;
			dist_x_q <= (target_x >= pos_x_q) ? target_x - pos_x_q : pos_x_q - target_x;
			dist_y_q <= (target_y >= pos_y_q) ? target_y - pos_y_q : pos_y_q - target_y;
			fx_q <= base_q;
			fy_q <= base_q;
			cmp_x_q <= '0;
			cmp_y_q <= '0;
		end
		if (state_q == xysmp_pkg::ST_NEXT && op_q == xysmp_pkg::OP_PY) begin
			slow_y_q <= need_y;
		end
		if (state_q == xysmp_pkg::ST_WAIT && div_sts.done) begin
			case (op_q)
				xysmp_pkg::OP_PX: px_q <= quotient[31:0];
				xysmp_pkg::OP_PY: py_q <= quotient[31:0];
				xysmp_pkg::OP_RATIO: begin
					if (slow_y_q) begin
						fy_q <= quotient[19:0];
					end else begin
						fx_q <= quotient[19:0];
					end
				end
				xysmp_pkg::OP_CMPX: cmp_x_q <= cmp_val;
				xysmp_pkg::OP_CMPY: cmp_y_q <= cmp_val;
				default: px_q <= px_q;
			endcase
		end
	end

	assign dir_x = dir_x_q;
	assign dir_y = dir_y_q;
	assign pulses_x = px_q;
	assign pulses_y = py_q;
	assign enable_x = en_x;
	assign enable_y = en_y;
	assign compare_x = cmp_x_q;
	assign compare_y = cmp_y_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.start |-> !div_sts.busy)
		else $error("divider restarted while busy");

	a_cmp_en: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((enable_x || compare_x == '0) && (enable_y || compare_y == '0)))
		else $error("compare set on disabled axis");

	a_slow_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pulses_x > pulses_y && pulses_y != '0) |-> (fy_q <= base_q && fx_q == base_q))
		else $error("wrong axis slowed");

	a_wait_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == xysmp_pkg::ST_WAIT && !div_sts.done) |-> div_sts.busy)
		else $error("waiting on idle divider");

endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import xysmp_pkg::*;

	localparam longint unsigned CLK_HZ = CLOCK_HZ_DEF;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int MOVES_PER_PHASE = 130;
	localparam int HOLDOFF_CYCLES = 400;

	typedef struct packed {
		logic dir_x;
		logic dir_y;
		logic [31:0] pulses_x;
		logic [31:0] pulses_y;
		logic enable_x;
		logic enable_y;
		logic [23:0] compare_x;
		logic [23:0] compare_y;
	} move_plan_t;

	typedef struct packed {
		logic is_cfg;
		cfg_idx_t reg_idx;
		logic [19:0] reg_data;
		logic [15:0] tx;
		logic [15:0] ty;
		logic typed;
		move_plan_t want;
	} step_row_t;

	localparam int N_DIRECTED = 26;
	localparam step_row_t DIRECTED_STEPS [N_DIRECTED] = '{
		'{0, CFG_PPR, 0, 16'd0, 16'd0, 1, '{1, 1, 0, 0, 1, 1, 799, 799}},
		'{0, CFG_PPR, 0, 16'd8, 16'd8, 1, '{1, 1, 1000, 1000, 1, 1, 799, 799}},
		'{0, CFG_PPR, 0, 16'hFFFF, 16'd8, 1, '{1, 1, 8190875, 0, 1, 1, 799, 799}},
		'{0, CFG_PPR, 0, 16'd0, 16'hFFFF, 0, '0},
		'{0, CFG_PPR, 0, 16'hFFFF, 16'hFFFE, 1, '{1, 0, 8191875, 125, 1, 0, 799, 0}},
		'{0, CFG_PPR, 0, 16'd300, 16'd200, 0, '0},
		'{1, CFG_PPR, 20'h0FFFF, 16'd0, 16'd0, 0, '0},
		'{1, CFG_PITCH, 20'h00000, 16'd0, 16'd0, 0, '0},
		'{0, CFG_PPR, 0, 16'd0, 16'd0, 0, '0},
		'{0, CFG_PPR, 0, 16'hFFFF, 16'hFFFF, 1,
			'{1, 1, 32'd4294836225, 32'd4294836225, 1, 1, 799, 799}},
		'{0, CFG_PPR, 0, 16'd0, 16'd1, 0, '0},
		'{1, CFG_BASE, 20'h00000, 16'd0, 16'd0, 0, '0},
		'{0, CFG_PPR, 0, 16'd5, 16'd6, 1, '{1, 1, 327675, 327675, 0, 0, 0, 0}},
		'{1, CFG_MIN, 20'h00000, 16'd0, 16'd0, 0, '0},
		'{0, CFG_PPR, 0, 16'd5, 16'd6, 1, '{1, 1, 0, 0, 0, 0, 0, 0}},
		'{1, CFG_BASE, 20'h00001, 16'd0, 16'd0, 0, '0},
		'{0, CFG_PPR, 0, 16'd6, 16'd6, 1, '{1, 1, 65535, 0, 1, 1, 7999999, 7999999}},
		'{1, CFG_BASE, 20'hFFFFF, 16'd0, 16'd0, 0, '0},
		'{0, CFG_PPR, 0, 16'd6, 16'd6, 1, '{1, 1, 0, 0, 1, 1, 6, 6}},
		'{1, CFG_MIN, 20'hFFFFF, 16'd0, 16'd0, 0, '0},
		'{0, CFG_PPR, 0, 16'd7, 16'd5, 1, '{1, 0, 65535, 65535, 0, 0, 0, 0}},
		'{1, CFG_PPR, 20'h00001, 16'd0, 16'd0, 0, '0},
		'{1, CFG_PITCH, 20'h000FF, 16'd0, 16'd0, 0, '0},
		'{1, CFG_BASE, 20'd10000, 16'd0, 16'd0, 0, '0},
		'{1, CFG_MIN, 20'd100, 16'd0, 16'd0, 0, '0},
		'{0, CFG_PPR, 0, 16'hFFFF, 16'd0, 1, '{1, 0, 256, 0, 1, 1, 799, 799}}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [15:0] target_x = '0;
	logic [15:0] target_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic dir_x;
	logic dir_y;
	logic [31:0] pulses_x;
	logic [31:0] pulses_y;
	logic enable_x;
	logic enable_y;
	logic [23:0] compare_x;
	logic [23:0] compare_y;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_index = CFG_PPR;
	logic [19:0] cfg_data = '0;

	// planner shadow: registers and current position
	logic [15:0] ppr_r = PPR_RST;
	logic [7:0] pitch_r = PITCH_RST;
	logic [19:0] base_r = BASE_RST;
	logic [19:0] min_r = MIN_RST;
	logic [15:0] cur_x = '0;
	logic [15:0] cur_y = '0;

	move_plan_t plan_q [$];
	int fail_count = 0;
	int src_idle_pct = 0;
	int rcv_idle_pct = 0;
	logic holdoff_req = 1'b0;
	int holdoff_left = 0;
	int cycle_cnt = 0;

	xy_stepper_move_planner u_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [23:0] timer_compare(longint unsigned freq);
		longint unsigned q;
		q = CLK_HZ / (freq * 2);
		if (q == 0)
			return '0;
		q = q - 1;
		if (q > longint'(COMPARE_MAX))
			q = longint'(COMPARE_MAX);
		return q[23:0];
	endfunction

	function automatic move_plan_t plan_move(logic [15:0] tx, logic [15:0] ty);
		move_plan_t p;
		logic [15:0] dx;
		logic [15:0] dy;
		longint unsigned pitch_eff;
		longint unsigned px;
		longint unsigned py;
		longint unsigned fx;
		longint unsigned fy;
		p.dir_x = (tx >= cur_x);
		p.dir_y = (ty >= cur_y);
		dx = p.dir_x ? tx - cur_x : cur_x - tx;
		dy = p.dir_y ? ty - cur_y : cur_y - ty;
		pitch_eff = (pitch_r == 0) ? 1 : 64'(pitch_r);
		px = (64'(dx) * 64'(ppr_r)) / pitch_eff;
		py = (64'(dy) * 64'(ppr_r)) / pitch_eff;
		fx = 64'(base_r);
		fy = 64'(base_r);
		if (px > py && py > 0)
			fy = (64'(base_r) * py) / px;
		else if (py > px && px > 0)
			fx = (64'(base_r) * px) / py;
		p.pulses_x = px[31:0];
		p.pulses_y = py[31:0];
		p.enable_x = (fx > 64'(min_r));
		p.enable_y = (fy > 64'(min_r));
		p.compare_x = p.enable_x ? timer_compare(fx) : '0;
		p.compare_y = p.enable_y ? timer_compare(fy) : '0;
		cur_x = tx;
		cur_y = ty;
		return p;
	endfunction

	function automatic logic [19:0] pick_reg(cfg_idx_t idx);
		int sel;
		logic [19:0] noise;
		sel = $urandom_range(15);
		noise = 20'($urandom);
		case (idx)
			CFG_PPR: begin
				noise[15:0] = (sel == 0) ? 16'h0 : (sel == 1) ? 16'hFFFF : (sel == 2) ? 16'h1 :
					16'($urandom_range(5000, 50));
			end
			CFG_PITCH: begin
				noise[7:0] = (sel == 0) ? 8'h0 : (sel == 1) ? 8'hFF : (sel == 2) ? 8'h1 :
					8'($urandom_range(16, 1));
			end
			CFG_BASE: begin
				noise = (sel == 0) ? 20'h0 : (sel == 1) ? 20'hFFFFF : (sel == 2) ? 20'h1 :
					20'($urandom_range(300000, 50));
			end
			default: begin
				noise = (sel == 0) ? 20'hFFFFF : (sel < 3) ? 20'h0 : 20'($urandom_range(20000));
			end
		endcase
		return noise;
	endfunction

	task automatic write_reg(cfg_idx_t idx, logic [19:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_PPR: ppr_r = data[15:0];
			CFG_PITCH: pitch_r = data[7:0];
			CFG_BASE: base_r = data;
			default: min_r = data;
		endcase
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		cfg_we <= 1'b0;
		while (plan_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_move(logic [15:0] tx, logic [15:0] ty, logic typed, move_plan_t want);
		move_plan_t plan;
		cfg_we <= 1'b0;
		if ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < src_idle_pct);
		end
		in_valid <= 1'b1;
		target_x <= tx;
		target_y <= ty;
		do
			@(posedge clk);
		while (in_stall);
		plan = plan_move(tx, ty);
		plan_q.push_back(typed ? want : plan);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	// result side: check each beat, then pick the next stall
	always @(posedge clk) begin : result_side
		move_plan_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (plan_q.size() == 0) begin
				$display("%0t: result beat with none expected", $time);
				fail_count++;
			end else begin
				want = plan_q.pop_front();
				check_field("dir_x", 32'(want.dir_x), 32'(dir_x));
				check_field("dir_y", 32'(want.dir_y), 32'(dir_y));
				check_field("pulses_x", want.pulses_x, pulses_x);
				check_field("pulses_y", want.pulses_y, pulses_y);
				check_field("enable_x", 32'(want.enable_x), 32'(enable_x));
				check_field("enable_y", 32'(want.enable_y), 32'(enable_y));
				check_field("compare_x", 32'(want.compare_x), 32'(compare_x));
				check_field("compare_y", 32'(want.compare_y), 32'(compare_y));
			end
		end
		if (holdoff_req) begin
			holdoff_req <= 1'b0;
			holdoff_left <= HOLDOFF_CYCLES;
			out_stall <= 1'b1;
		end else if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("testbench failed");
		$finish;
	end

	initial begin
		int sel;
		int d;
		logic [15:0] tx;
		logic [15:0] ty;
		step_row_t row;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 22;
		rcv_idle_pct = 82;
		for (int i = 0; i < N_DIRECTED; i++) begin
			row = DIRECTED_STEPS[i];
			if (row.is_cfg) begin
				wait_drained();
				write_reg(row.reg_idx, row.reg_data);
			end else begin
				send_move(row.tx, row.ty, row.typed, row.want);
			end
		end

		for (int m = 0; m < 3; m++) begin
			src_idle_pct = (m == 0) ? 22 : (m == 1) ? 82 : 0;
			rcv_idle_pct = (m == 0) ? 82 : (m == 1) ? 22 : 0;
			for (int ph = 0; ph < 4; ph++) begin
				wait_drained();
				for (int r = 0; r < 4; r++)
					write_reg(cfg_idx_t'(r), pick_reg(cfg_idx_t'(r)));
				for (int n = 0; n < MOVES_PER_PHASE; n++) begin
					if (m == 2 && ph == 0 && n == 20)
						holdoff_req <= 1'b1;
					if (m == 1 && ph == 1 && n == 60)
						wait_drained();
					sel = $urandom_range(9);
					case (sel)
						0, 1, 2, 3: begin
							tx = cur_x + 16'($urandom_range(600)) - 16'd300;
							ty = cur_y + 16'($urandom_range(600)) - 16'd300;
						end
						4, 5: begin
							tx = 16'($urandom);
							ty = 16'($urandom);
						end
						6: begin
							if ($urandom_range(1)) begin
								tx = cur_x;
								ty = 16'($urandom);
							end else begin
								tx = 16'($urandom);
								ty = cur_y;
							end
						end
						7: begin
							d = $urandom_range(2000);
							tx = $urandom_range(1) ? cur_x + 16'(d) : cur_x - 16'(d);
							ty = $urandom_range(1) ? cur_y + 16'(d) : cur_y - 16'(d);
						end
						8: begin
							tx = cur_x;
							ty = cur_y;
						end
						default: begin
							tx = $urandom_range(1) ? 16'hFFFF : 16'h0000;
							ty = $urandom_range(1) ? 16'hFFFF : 16'h0000;
						end
					endcase
					send_move(tx, ty, 1'b0, '0);
				end
			end
		end

		wait_drained();
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

[xy_stepper_move_planner.f]
rtl/core/xysmp_pkg.sv
rtl/core/xysmp_div.sv
rtl/core/xy_stepper_move_planner.sv
verif/testbench.sv
